/* rtl/rmsef_pkg.sv */
// ----------------------------------------------------------------------------
// rmsef_pkg
// Shared widths, constants and register map of the rms envelope follower.
// ----------------------------------------------------------------------------
package rmsef_pkg;

	// default sample width and coefficient fraction bits
	localparam int SAMPLE_WIDTH    = 16;
	localparam int COEFF_FRAC_BITS = 16;

	// mean square: 48 bits with 16 fraction bits
	localparam int MS_W    = 48;
	localparam int MS_FRAC = 16;
	localparam int IPART_W = MS_W - MS_FRAC;

	// shared multiplier operand width, product is twice that
	localparam int MUL_W  = 24;
	localparam int PROD_W = 2 * MUL_W;

	// square root result
	localparam int ROOT_W = 16;
	localparam int LEVEL_W = 16;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int COEFF_W = 16;
	localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd15;

	// register indexes
	typedef enum logic {
		REG_COEFF = 1'b0,
		REG_NONE  = 1'b1
	} reg_idx_t;

endpackage

/* rtl/rmsef_in_if.sv */
// ----------------------------------------------------------------------------
// rmsef_in_if
// Sample channel: one signed sample and a block start flag per beat.
// ----------------------------------------------------------------------------
interface rmsef_in_if #(
	parameter int SAMPLE_WIDTH = rmsef_pkg::SAMPLE_WIDTH
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           block_start;

	modport source (output valid, sample, block_start, input ready);
	modport sink   (input valid, sample, block_start, output ready);
endinterface

/* rtl/rmsef_out_if.sv */
// ----------------------------------------------------------------------------
// rmsef_out_if
// Level channel: one rms level per beat.
// ----------------------------------------------------------------------------
interface rmsef_out_if ();
	logic                               valid;
	logic                               ready;
	logic [rmsef_pkg::LEVEL_W-1:0]      rms_level;

	modport source (output valid, rms_level, input ready);
	modport sink   (input valid, rms_level, output ready);
endinterface

/* rtl/rmsef_mul.sv */
// ----------------------------------------------------------------------------
// rmsef_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module rmsef_mul (
	input  logic                           clk,
	input  logic [rmsef_pkg::MUL_W-1:0]    op_a,
	input  logic [rmsef_pkg::MUL_W-1:0]    op_b,
	output logic [rmsef_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= rmsef_pkg::PROD_W'(op_a) * rmsef_pkg::PROD_W'(op_b);
	end

endmodule

/* rtl/rmsef_isqrt.sv */
// ----------------------------------------------------------------------------
// rmsef_isqrt
// Floor square root, one result bit per cycle over two radicand bits.
// ----------------------------------------------------------------------------
module rmsef_isqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rmsef_pkg::IPART_W-1:0]    radicand,
	output logic                             done_q,
	output logic [rmsef_pkg::ROOT_W-1:0]     root_q
);

	localparam int ROOT_W = rmsef_pkg::ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int RAD_W  = rmsef_pkg::IPART_W;
	localparam int CNT_W  = $clog2(ROOT_W);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

endmodule

/* rtl/rms_envelope_follower.sv */
// ----------------------------------------------------------------------------
// rms_envelope_follower
// One-pole mean-square smoother with an iterative floor square root.
// A new sample is taken only in the idle state, once the previous level
// has been loaded into the result register; each sample makes three passes
// through the shared multiplier, the wide add stages and the 16-step root loop.
// Reset clears the mean square to zero and sets the coefficient to 15.
// ----------------------------------------------------------------------------
module rms_envelope_follower #(
	parameter int SAMPLE_WIDTH    = rmsef_pkg::SAMPLE_WIDTH,
	parameter int COEFF_FRAC_BITS = rmsef_pkg::COEFF_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rmsef_in_if.sink                        samples,
	rmsef_out_if.source                     levels,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rmsef_pkg::PADDR_W-1:0]   paddr,
	input  logic [rmsef_pkg::PDATA_W-1:0]   pwdata,
	output logic [rmsef_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);

	localparam int MS_W     = rmsef_pkg::MS_W;
	localparam int MS_FRAC  = rmsef_pkg::MS_FRAC;
	localparam int MUL_W    = rmsef_pkg::MUL_W;
	localparam int PROD_W   = rmsef_pkg::PROD_W;
	localparam int COEFF_W  = rmsef_pkg::COEFF_W;
	localparam int HI_SHIFT = MUL_W - COEFF_FRAC_BITS;
	localparam logic [MUL_W-1:0]  COEFF_MAX  = MUL_W'((1 << COEFF_FRAC_BITS) - 1);
	localparam logic [PROD_W-1:0] FRAC_MASK  = PROD_W'((1 << COEFF_FRAC_BITS) - 1);
	localparam logic [MS_W-1:0]   MS_MAX     = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_TGT,
		ST_DIFF,
		ST_MHI,
		ST_MLO,
		ST_STEP,
		ST_UPD,
		ST_RGO,
		ST_RWAIT,
		ST_OUT
	} state_t;

	state_t                    state_q;
	logic [COEFF_W-1:0]        coeff_q;
	logic [MS_W-1:0]           ms_q;
	logic                      out_valid_q;
	logic [rmsef_pkg::LEVEL_W-1:0] rms_q;

	logic [SAMPLE_WIDTH-1:0]   raw_q;
	logic [MS_W-1:0]           target_q;
	logic [MS_W-1:0]           dmag_q;
	logic                      up_q;
	logic [PROD_W-1:0]         hi_q;
	logic [MS_W:0]             step_q;

	logic [SAMPLE_WIDTH-1:0]   mag;
	logic [MUL_W-1:0]          coeff_ext;
	logic [MUL_W-1:0]          coeff_sat;
	logic [MUL_W-1:0]          op_a;
	logic [MUL_W-1:0]          op_b;
	logic [PROD_W-1:0]         prod_q;
	logic [MS_W:0]             t_minus_m;
	logic [MS_W-1:0]           step_sum;
	logic                      inexact;
	logic [MS_W:0]             ms_add;
	logic [MS_W+1:0]           ms_sub;
	logic [MS_W-1:0]           ms_next;
	logic                      sq_start;
	logic                      sq_done;
	logic [rmsef_pkg::ROOT_W-1:0] root;
	logic                      load_out;
	logic                      cfg_wr;
	rmsef_pkg::reg_idx_t       cfg_idx;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = rmsef_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && (cfg_idx == rmsef_pkg::REG_COEFF);

	always_comb begin
		case (cfg_idx)
			rmsef_pkg::REG_COEFF: prdata = rmsef_pkg::PDATA_W'(coeff_q);
			default:              prdata = '0;
		endcase
	end

	assign samples.ready   = (state_q == ST_IDLE);
	assign levels.valid     = out_valid_q;
	assign levels.rms_level = rms_q;

	// result register free, or emptied on this beat
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || levels.ready);

	// magnitude of the sample, the most negative code maps onto itself
	always_comb begin
		mag       = raw_q[SAMPLE_WIDTH-1] ? (~raw_q + 1'b1) : raw_q;
		coeff_ext = MUL_W'(coeff_q);
		coeff_sat = (coeff_ext > COEFF_MAX) ? COEFF_MAX : coeff_ext;
	end

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_SQ: begin
				op_a = MUL_W'(mag);
				op_b = MUL_W'(mag);
			end
			ST_MHI: begin
				op_a = dmag_q[MS_W-1:MUL_W];
				op_b = coeff_sat;
			end
			ST_MLO: begin
				op_a = dmag_q[MUL_W-1:0];
				op_b = coeff_sat;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	rmsef_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	always_comb begin
		t_minus_m = {1'b0, target_q} - {1'b0, ms_q};
		// floor(dmag * c / 2^F) from the high and low partial products
		step_sum  = MS_W'(hi_q << HI_SHIFT) + MS_W'(prod_q >> COEFF_FRAC_BITS);
		inexact   = (prod_q & FRAC_MASK) != '0;
		ms_add    = {1'b0, ms_q} + step_q;
		ms_sub    = {2'b00, ms_q} - {1'b0, step_q};
		if (up_q) begin
			ms_next = ms_add[MS_W] ? MS_MAX : ms_add[MS_W-1:0];
		end else begin
			ms_next = ms_sub[MS_W+1] ? '0 : ms_sub[MS_W-1:0];
		end
	end

	assign sq_start = (state_q == ST_RGO);

	rmsef_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (ms_q[MS_W-1:MS_FRAC]),
		.done_q   (sq_done),
		.root_q   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			coeff_q     <= rmsef_pkg::COEFF_RESET;
			ms_q        <= '0;
			out_valid_q <= 1'b0;
			rms_q       <= '0;
		end else begin
			if (cfg_wr) begin
				coeff_q <= pwdata[COEFF_W-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (levels.valid && levels.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						if (samples.block_start) begin
							ms_q <= '0;
						end
						state_q <= ST_SQ;
					end
				end
				ST_SQ:    state_q <= ST_TGT;
				ST_TGT:   state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_MHI;
				ST_MHI:   state_q <= ST_MLO;
				ST_MLO:   state_q <= ST_STEP;
				ST_STEP:  state_q <= ST_UPD;
				ST_UPD: begin
					ms_q    <= ms_next;
					state_q <= ST_RGO;
				end
				ST_RGO:   state_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (sq_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						rms_q   <= root;
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				raw_q <= samples.sample;
			end
			ST_TGT: begin
				// square saturates once it no longer fits the integer part
				target_q <= (prod_q[PROD_W-1:MS_W-MS_FRAC] != '0) ? MS_MAX :
					{prod_q[MS_W-MS_FRAC-1:0], {MS_FRAC{1'b0}}};
			end
			ST_DIFF: begin
				up_q   <= !t_minus_m[MS_W];
				dmag_q <= t_minus_m[MS_W] ? (ms_q - target_q) : t_minus_m[MS_W-1:0];
			end
			ST_MLO: begin
				hi_q <= prod_q;
			end
			ST_STEP: begin
				// falling mean rounds toward minus infinity
				step_q <= {1'b0, step_sum} + (MS_W + 1)'(!up_q && inexact);
			end
			default: begin
			end
		endcase
	end

endmodule
